// ===== hw/rtl/three_bit_vm_execute_core_defines.svh =====
// Assertion macros used by the checker of the execute core.
// Each macro expects a signal named clk and a signal named rst in the scope where it is used.
`ifndef THREE_BIT_VM_EXECUTE_CORE_DEFINES_SVH
`define THREE_BIT_VM_EXECUTE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBVM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TBVM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tbvm_pkg.sv =====
package tbvm_pkg;

  // Capacity of the program store seen by the fetcher.
  localparam int unsigned PROGRAM_WORDS = 64;
  // Entries between the decode side and the execute side.
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned CODE_W = 3;
  localparam int unsigned PC_W   = 7;
  localparam int unsigned LEN_W  = 7;
  // Internal counter has one more bit, so that a step past the last word still halts.
  localparam int unsigned CNT_PC_W = PC_W + 1;
  localparam int unsigned SHAMT_W  = $clog2(WORD_W);

  typedef enum logic [0:0] {
    REQ_EXEC    = 1'b0,
    REQ_RESTART = 1'b1
  } req_kind_t;

  typedef enum logic [2:0] {
    OP_ADV = 3'd0,
    OP_BXL = 3'd1,
    OP_BST = 3'd2,
    OP_JNZ = 3'd3,
    OP_BXC = 3'd4,
    OP_OUT = 3'd5,
    OP_BDV = 3'd6,
    OP_CDV = 3'd7
  } op_t;

  // Source of a combo operand.
  typedef enum logic [1:0] {
    SEL_LIT,
    SEL_A,
    SEL_B,
    SEL_C
  } sel_t;

  typedef enum logic [1:0] {
    CFG_START_A  = 2'd0,
    CFG_START_B  = 2'd1,
    CFG_START_C  = 2'd2,
    CFG_PROG_LEN = 2'd3
  } cfg_idx_t;

  localparam logic [CODE_W-1:0] COMBO_A = 3'd4;
  localparam logic [CODE_W-1:0] COMBO_B = 3'd5;
  localparam logic [CODE_W-1:0] COMBO_C = 3'd6;

  // One classified request as it waits in the queue.
  typedef struct packed {
    logic              restart;
    op_t               op;
    sel_t              sel;
    logic [CODE_W-1:0] arg;
  } dec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [WORD_W-1:0] start_a;
    logic [WORD_W-1:0] start_b;
    logic [WORD_W-1:0] start_c;
    logic [LEN_W-1:0]  eff_len;
  } cfg_t;

endpackage

// ===== hw/rtl/tbvm_ifs.sv =====
// Request channel: one instruction or restart per request.
interface tbvm_req_if import tbvm_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [CODE_W-1:0] opcode;
  logic [CODE_W-1:0] operand;

  modport source (output valid, output req_type, output opcode, output operand, input ready);
  modport sink   (input valid, input req_type, input opcode, input operand, output ready);
endinterface

// Result channel: one result per request.
interface tbvm_rsp_if import tbvm_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              out_valid;
  logic [CODE_W-1:0] out_value;
  logic [PC_W-1:0]   next_pc;
  logic              halted;

  modport source (output valid, output out_valid, output out_value, output next_pc,
                  output halted, input ready);
  modport sink   (input valid, input out_valid, input out_value, input next_pc,
                  input halted, output ready);
endinterface

// ===== hw/rtl/three_bit_vm_execute_core.sv =====
// Channel   Role    Payload
// req       sink    req_type, opcode, operand
// rsp       source  out_valid, out_value, next_pc, halted
//
// One request per cycle is sustained while rsp.ready holds; a taken request is written to a
// queue entry, then passes the execute step and is captured in the result register.
// The execute step is combinational: combo select, 64-bit right shifter and xor.
// The two-entry queue keeps taking requests, until it is full, while a result waits for rsp.ready.
// Synchronous reset clears the machine registers, the config registers and the queue.
module three_bit_vm_execute_core import tbvm_pkg::*;
  (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [WORD_W-1:0] cfg_data,
  tbvm_req_if.sink          req,
  tbvm_rsp_if.source        rsp
);

  localparam logic [LEN_W+1:0] WORDS_LIM = (LEN_W + 2)'(PROGRAM_WORDS);

  logic [WORD_W-1:0] start_a;
  logic [WORD_W-1:0] start_b;
  logic [WORD_W-1:0] start_c;
  logic [LEN_W-1:0]  prog_len;
  cfg_t              cfg;
  q_stat_t           q_stat;
  dec_t              push_data;
  dec_t              head;
  logic              push;
  logic              pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_a  <= '0;
      start_b  <= '0;
      start_c  <= '0;
      prog_len <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_START_A:  start_a  <= cfg_data;
        CFG_START_B:  start_b  <= cfg_data;
        CFG_START_C:  start_c  <= cfg_data;
        CFG_PROG_LEN: prog_len <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // A length beyond the program store counts as the store size.
  always_comb begin
    cfg.start_a = start_a;
    cfg.start_b = start_b;
    cfg.start_c = start_c;
    if ((LEN_W + 2)'(prog_len) > WORDS_LIM) begin
      cfg.eff_len = LEN_W'(PROGRAM_WORDS);
    end else begin
      cfg.eff_len = prog_len;
    end
  end

  tbvm_front u_front (
    .req       (req),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  tbvm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  tbvm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .rsp    (rsp)
  );

endmodule

// ===== hw/rtl/tbvm_front.sv =====
module tbvm_front import tbvm_pkg::*;
  (
  tbvm_req_if.sink req,
  input  q_stat_t  q_stat,
  output logic     push,
  output dec_t     push_data
);

  // A request is taken whenever the queue has room.
  assign req.ready = !q_stat.full;
  assign push      = req.valid && !q_stat.full;

  // Classify the request and resolve where the combo operand comes from.
  always_comb begin
    push_data.restart = (req_kind_t'(req.req_type) == REQ_RESTART);
    push_data.op      = op_t'(req.opcode);
    push_data.arg     = req.operand;
    case (req.operand)
      COMBO_A: push_data.sel = SEL_A;
      COMBO_B: push_data.sel = SEL_B;
      COMBO_C: push_data.sel = SEL_C;
      default: push_data.sel = SEL_LIT;
    endcase
  end

endmodule

// ===== hw/rtl/tbvm_queue.sv =====
module tbvm_queue import tbvm_pkg::*;
  (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  dec_t    push_data,
  input  logic    pop,
  output dec_t    head,
  output q_stat_t q_stat
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  dec_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] ptr);
    return (ptr == LAST_PTR) ? '0 : ptr + PTR_W'(1);
  endfunction

  assign q_stat.full  = (count == FULL_CNT);
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

endmodule

// ===== hw/rtl/tbvm_back.sv =====
module tbvm_back import tbvm_pkg::*;
  (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  dec_t    head,
  input  q_stat_t q_stat,
  output logic    pop,
  tbvm_rsp_if.source rsp
);

  logic [WORD_W-1:0]   reg_a;
  logic [WORD_W-1:0]   reg_b;
  logic [WORD_W-1:0]   reg_c;
  logic [CNT_PC_W-1:0] pc;

  logic [WORD_W-1:0]   reg_a_next;
  logic [WORD_W-1:0]   reg_b_next;
  logic [WORD_W-1:0]   reg_c_next;
  logic [CNT_PC_W-1:0] pc_next;
  logic                out_valid_next;
  logic [CODE_W-1:0]   out_value_next;
  logic                halted_next;

  logic                res_valid;
  logic                res_out_valid;
  logic [CODE_W-1:0]   res_out_value;
  logic [PC_W-1:0]     res_next_pc;
  logic                res_halted;

  logic [WORD_W-1:0]   combo;
  logic [WORD_W-1:0]   shifted;
  logic [CNT_PC_W-1:0] len_ext;
  logic                running;
  logic                fire;

  // Take the queue head when the result register is free or being emptied.
  assign fire    = !q_stat.empty && (!res_valid || rsp.ready);
  assign pop     = fire;
  assign len_ext = CNT_PC_W'(cfg.eff_len);
  assign running = (pc < len_ext);

  // Combo operand and the shared right shifter; counts of 64 and up give zero.
  always_comb begin
    case (head.sel)
      SEL_A:   combo = reg_a;
      SEL_B:   combo = reg_b;
      SEL_C:   combo = reg_c;
      default: combo = WORD_W'(head.arg);
    endcase
    if (|combo[WORD_W-1:SHAMT_W]) begin
      shifted = '0;
    end else begin
      shifted = reg_a >> combo[SHAMT_W-1:0];
    end
  end

  // Execute one request. A halted machine ignores instructions.
  always_comb begin
    reg_a_next     = reg_a;
    reg_b_next     = reg_b;
    reg_c_next     = reg_c;
    pc_next        = pc;
    out_valid_next = 1'b0;
    out_value_next = '0;
    if (head.restart) begin
      reg_a_next = cfg.start_a;
      reg_b_next = cfg.start_b;
      reg_c_next = cfg.start_c;
      pc_next    = '0;
    end else if (running) begin
      pc_next = pc + CNT_PC_W'(2);
      case (head.op)
        OP_ADV: reg_a_next = shifted;
        OP_BXL: reg_b_next = reg_b ^ WORD_W'(head.arg);
        OP_BST: reg_b_next = WORD_W'(combo[CODE_W-1:0]);
        OP_JNZ: begin
          if (reg_a != '0) pc_next = CNT_PC_W'(head.arg);
        end
        OP_BXC: reg_b_next = reg_b ^ reg_c;
        OP_OUT: begin
          out_valid_next = 1'b1;
          out_value_next = combo[CODE_W-1:0];
        end
        OP_BDV: reg_b_next = shifted;
        OP_CDV: reg_c_next = shifted;
        default: reg_c_next = shifted;
      endcase
    end
    halted_next = (pc_next >= len_ext);
  end

  // Machine state and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_a     <= '0;
      reg_b     <= '0;
      reg_c     <= '0;
      pc        <= '0;
      res_valid <= 1'b0;
    end else begin
      if (fire) begin
        reg_a     <= reg_a_next;
        reg_b     <= reg_b_next;
        reg_c     <= reg_c_next;
        pc        <= pc_next;
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      res_out_valid <= out_valid_next;
      res_out_value <= out_value_next;
      res_next_pc   <= pc_next[PC_W-1:0];
      res_halted    <= halted_next;
    end
  end

  assign rsp.valid     = res_valid;
  assign rsp.out_valid = res_out_valid;
  assign rsp.out_value = res_out_value;
  assign rsp.next_pc   = res_next_pc;
  assign rsp.halted    = res_halted;

endmodule

// ===== hw/rtl/tbvm_checker.sv =====
`include "three_bit_vm_execute_core_defines.svh"

module tbvm_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       out_valid,
  input logic [2:0] out_value,
  input logic [6:0] next_pc,
  input logic       halted
);

  // A stalled result keeps its contents.
  `TBVM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({out_valid, out_value, next_pc, halted}), "stalled result changed")

  // Only an output instruction carries a value.
  `TBVM_ASSERT_SAME(a_value_zero, rsp_valid && !out_valid, out_value == 3'd0, "value without output instruction")

  // A running machine never sits on the last counter value.
  `TBVM_ASSERT_SAME(a_pc_range, rsp_valid && !halted, next_pc != 7'h7f, "running at impossible counter")

  // Two requests taken while the result stalls fill the queue.
  `TBVM_ASSERT_NEXT(a_queue_fill, (req_valid && req_ready && rsp_valid && !rsp_ready) ##1 (req_valid && req_ready && rsp_valid && !rsp_ready), !req_ready, "queue overran during stall")

endmodule

bind three_bit_vm_execute_core tbvm_checker u_tbvm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .out_valid (rsp.out_valid),
  .out_value (rsp.out_value),
  .next_pc   (rsp.next_pc),
  .halted    (rsp.halted)
);
